// File: sv/ttnt_pkg.sv
// Package for the transient-triggered noise texture block.
// Holds constants and the sequencer state type; no dependencies.
`default_nettype none
package ttnt_pkg;
    localparam int unsigned HOLDOFF_SAMPLES_DEF = 3528;
    localparam int unsigned NUM_CHANNELS_DEF    = 2;
    localparam int unsigned SAMPLE_BITS_DEF     = 24;
    localparam logic [31:0] LFSR_SEED     = 32'hACE1ACE1;
    localparam logic [31:0] LFSR_MASK     = 32'hD0000001;
    localparam logic [31:0] CRACKLE_LIMIT = 32'd128849019;
    localparam logic [23:0] WIND_COEF     = 24'd167772;
    localparam logic [24:0] TEX_ONE       = 25'd16777216;
    localparam logic [4:0]  HOLD_STEPS    = 5'd20;
    localparam logic [16:0] MIX_FULL      = 17'd65536;

    localparam logic [2:0] REG_THRESH  = 3'd0;
    localparam logic [2:0] REG_PALETTE = 3'd1;
    localparam logic [2:0] REG_DECAY   = 3'd2;
    localparam logic [2:0] REG_MIX     = 3'd3;
    localparam logic [2:0] REG_FATT    = 3'd4;
    localparam logic [2:0] REG_FREL    = 3'd5;
    localparam logic [2:0] REG_SATT    = 3'd6;
    localparam logic [2:0] REG_SREL    = 3'd7;

    localparam logic [1:0] PAL_CRACKLE = 2'd0;
    localparam logic [1:0] PAL_SCRAPE  = 2'd1;
    localparam logic [1:0] PAL_WIND    = 2'd2;
    localparam logic [1:0] PAL_GLITCH  = 2'd3;

    // Sequencer steps, one-hot.
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FAST  = 10'b0000000010,
        S_SLOW  = 10'b0000000100,
        S_HIT   = 10'b0000001000,
        S_DECAY = 10'b0000010000,
        S_NOISE = 10'b0000100000,
        S_TEX   = 10'b0001000000,
        S_GAIN  = 10'b0010000000,
        S_MIX   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;
endpackage
`default_nettype wire

// File: sv/transient_triggered_noise_texture.sv
// Top level of the transient-triggered noise texture block.
// Uses ttnt_pkg; one shared signed multiplier under a step sequencer.
//
// Channel   Direction  Payload
// s_axis    in         tuser = chan, tdata = sample_in
// m_axis    out        tdata = sample_out
// apb       in/out     eight configuration registers at 4*i
//
// A result is written to the output register in the output step; the next request
// is taken only once the sequencer is back in idle. The nine steps are fast,
// slow, hit, decay, noise, texture, gain, mix and output. The shared multiplier
// is used once in each of the fast, slow, decay, gain and mix steps, and in the
// texture step for the wind palette. A new item is taken once the sequencer is
// idle and the result register is empty or being drained. Reset is synchronous
// and active low; it restores the register defaults, clears the channel state and seeds the LFSR.
`default_nettype none
module transient_triggered_noise_texture
    import ttnt_pkg::*;
#(
    parameter int unsigned HOLDOFF_SAMPLES = HOLDOFF_SAMPLES_DEF,
    parameter int unsigned NUM_CHANNELS    = NUM_CHANNELS_DEF,
    parameter int unsigned SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [SAMPLE_BITS-1:0] s_axis_tdata,  // [SB-1:0] sample_in
    input  wire logic                   s_axis_tuser,  // [0] chan
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [SAMPLE_BITS-1:0]      m_axis_tdata,  // [SB-1:0] sample_out
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [4:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int SB = SAMPLE_BITS;
    localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int W = SB + 30;   // working width for products and sums
    localparam int MW = SB + 3;   // multiplier operand width, holds any difference
    localparam logic signed [W-1:0] ONE = W'(1) <<< (SB - 1);

    // Configuration registers.
    logic [22:0] r_thresh;
    logic [1:0]  r_pal;
    logic [23:0] r_decay, r_fatt, r_frel, r_satt, r_srel;
    logic [16:0] r_mix;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0; r_pal <= '0; r_decay <= 24'hFFFFFF; r_mix <= '0;
            r_fatt <= '0; r_frel <= '0; r_satt <= '0; r_srel <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                REG_THRESH:  r_thresh <= pwdata[22:0];
                REG_PALETTE: r_pal    <= pwdata[1:0];
                REG_DECAY:   r_decay  <= pwdata[23:0];
                REG_MIX:     r_mix    <= pwdata[16:0];
                REG_FATT:    r_fatt   <= pwdata[23:0];
                REG_FREL:    r_frel   <= pwdata[23:0];
                REG_SATT:    r_satt   <= pwdata[23:0];
                REG_SREL:    r_srel   <= pwdata[23:0];
                default:     ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        prdata = '0;
        unique case (paddr[4:2])
            REG_THRESH:  prdata = 32'(r_thresh);
            REG_PALETTE: prdata = 32'(r_pal);
            REG_DECAY:   prdata = 32'(r_decay);
            REG_MIX:     prdata = 32'(r_mix);
            REG_FATT:    prdata = 32'(r_fatt);
            REG_FREL:    prdata = 32'(r_frel);
            REG_SATT:    prdata = 32'(r_satt);
            REG_SREL:    prdata = 32'(r_srel);
            default:     prdata = '0;
        endcase
    end

    // Per-channel state.
    logic [SB-1:0]        r_fenv [NUM_CHANNELS];
    logic [SB-1:0]        r_senv [NUM_CHANNELS];
    logic [24:0]          r_tenv [NUM_CHANNELS];
    logic [4:0]           r_hph  [NUM_CHANNELS];
    logic signed [SB-1:0] r_fmem [NUM_CHANNELS];
    logic [15:0]          r_hold [NUM_CHANNELS];
    logic [31:0]          r_lfsr;

    t_state r_st;
    logic [CHW-1:0]       r_ch;
    logic signed [W-1:0]  r_x, r_mag, r_fe, r_se, r_env, r_tex, r_fm, r_acc;
    logic [4:0]           r_ph;
    logic [15:0]          r_ho;
    logic                 r_ovalid, r_bypass;
    logic [SB-1:0]        r_odata;

    // Shared multiplier: operand a (signed) times operand b (26-bit).
    logic signed [MW-1:0]  m_a;
    logic signed [25:0]    m_b;
    logic signed [MW+25:0] m_p;
    logic signed [W-1:0]   m_q;   // floor(product / 2^24)
    assign m_p = m_a * m_b;
    assign m_q = W'(m_p >>> 24);

    function automatic logic [31:0] lfsr_step(input logic [31:0] v);
        lfsr_step = v[0] ? ((v >> 1) ^ LFSR_MASK) : (v >> 1);
    endfunction

    logic [31:0] l1, l2;
    logic signed [W-1:0] noise, hp_m, hp_d;
    logic [4:0] ph_inc;
    assign l1 = lfsr_step(r_lfsr);
    assign l2 = lfsr_step(l1);
    assign noise = W'($signed({1'b0, l1[31 -: SB]})) - ONE;
    assign ph_inc = r_ph + 5'd1;
    assign hp_m = r_fm + ((noise - r_fm) >>> 1);
    assign hp_d = noise - hp_m;

    // Operand selection per step.
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (r_st)
            S_FAST:  begin
                m_a = MW'(r_mag - r_fe);
                m_b = 26'(r_mag > r_fe ? r_fatt : r_frel);
            end
            S_SLOW:  begin
                m_a = MW'(r_mag - r_se);
                m_b = 26'(r_mag > r_se ? r_satt : r_srel);
            end
            S_DECAY: begin m_a = MW'(r_env); m_b = 26'(r_decay); end
            S_TEX:   begin m_a = MW'(noise - r_fm); m_b = 26'(WIND_COEF); end
            S_GAIN:  begin
                m_a = MW'(r_env);
                m_b = 26'((r_mix > MIX_FULL) ? MIX_FULL : r_mix) <<< 8;
            end
            S_MIX:   begin m_a = MW'(r_tex - r_x); m_b = 26'(r_acc[25:0]); end
            default: ;
        endcase
    end

    logic take;
    assign s_axis_tready = (r_st == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign take = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ovalid <= 1'b0;
            r_lfsr <= LFSR_SEED;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_fenv[i] <= '0; r_senv[i] <= '0; r_tenv[i] <= '0;
                r_hph[i] <= '0; r_fmem[i] <= '0; r_hold[i] <= '0;
            end
        end else begin
            if (m_axis_tready && r_ovalid) r_ovalid <= 1'b0;
            unique case (r_st)
                S_IDLE: if (take) begin
                    r_x <= W'($signed(s_axis_tdata));
                    r_mag <= s_axis_tdata[SB-1] ? -W'($signed(s_axis_tdata))
                                                :  W'($signed(s_axis_tdata));
                    r_bypass <= 32'(s_axis_tuser) >= NUM_CHANNELS;
                    r_ch <= CHW'(s_axis_tuser);
                    r_fe <= W'(r_fenv[CHW'(s_axis_tuser)]);
                    r_se <= W'(r_senv[CHW'(s_axis_tuser)]);
                    r_env <= W'(r_tenv[CHW'(s_axis_tuser)]);
                    r_ph <= r_hph[CHW'(s_axis_tuser)];
                    r_fm <= W'(r_fmem[CHW'(s_axis_tuser)]);
                    r_ho <= r_hold[CHW'(s_axis_tuser)];
                    r_st <= (32'(s_axis_tuser) >= NUM_CHANNELS) ? S_OUT : S_FAST;
                end
                S_FAST: begin r_fe <= r_fe + m_q; r_st <= S_SLOW; end
                S_SLOW: begin r_se <= r_se + m_q; r_st <= S_HIT; end
                S_HIT: begin
                    // Holdoff counts down first; a hit then needs it at zero.
                    if (((r_fe <<< 1) > (r_se * 5)) && (r_fe > W'(r_thresh))
                        && r_ho <= 16'd1) begin
                        r_env <= W'(TEX_ONE);
                        r_ho <= 16'(HOLDOFF_SAMPLES);
                    end else if (r_ho != 0) begin
                        r_ho <= r_ho - 16'd1;
                    end
                    r_st <= S_DECAY;
                end
                S_DECAY: begin r_acc <= m_q; r_st <= S_NOISE; end
                S_NOISE: begin
                    // Palette work that needs no multiplier.
                    unique case (r_pal)
                        PAL_CRACKLE: r_tex <= (l2 < CRACKLE_LIMIT) ? noise <<< 1 : '0;
                        PAL_SCRAPE: begin
                            r_fm <= hp_m;
                            r_tex <= hp_d + (hp_d >>> 1);
                        end
                        PAL_GLITCH: begin
                            if (ph_inc > HOLD_STEPS) begin
                                r_ph <= ph_inc - HOLD_STEPS;
                                r_fm <= noise;
                                r_tex <= noise + (noise >>> 1);
                            end else begin
                                r_ph <= ph_inc;
                                r_tex <= r_fm + (r_fm >>> 1);
                            end
                        end
                        default: ;
                    endcase
                    r_st <= S_TEX;
                end
                S_TEX: begin
                    if (r_pal == PAL_WIND) begin
                        r_fm <= r_fm + m_q;
                        r_tex <= (r_fm + m_q) * 6;
                    end
                    r_lfsr <= (r_pal == PAL_CRACKLE) ? l2 : l1;
                    r_st <= S_GAIN;
                end
                S_GAIN: begin
                    // Store env*mix and clip the texture; decayed env goes back to the channel.
                    r_tenv[r_ch] <= r_acc[24:0];
                    r_acc <= m_q;
                    if (r_tex > ONE) r_tex <= ONE;
                    else if (r_tex < -ONE) r_tex <= -ONE;
                    r_st <= S_MIX;
                end
                S_MIX: begin
                    r_acc <= r_x + m_q;
                    r_fenv[r_ch] <= r_fe[SB-1:0];
                    r_senv[r_ch] <= r_se[SB-1:0];
                    r_hph[r_ch] <= r_ph;
                    r_fmem[r_ch] <= r_fm[SB-1:0];
                    r_hold[r_ch] <= r_ho;
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (r_bypass) r_odata <= r_x[SB-1:0];
                    else if (r_acc > ONE - 1) r_odata <= SB'(ONE - 1);
                    else if (r_acc < -ONE) r_odata <= SB'(-ONE);
                    else r_odata <= r_acc[SB-1:0];
                    r_ovalid <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_st)) else $error("sequencer state not one-hot");
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT) |=> r_ovalid) else $error("result not posted");
    a_lfsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 32'd0) else $error("noise register stuck at zero");
`endif
endmodule
`default_nettype wire

// File: tb/transient_triggered_noise_texture_test.sv
// Self-checking testbench for the transient-triggered noise texture block.
// Depends on ttnt_pkg and transient_triggered_noise_texture; predicts each sample in-line.
`default_nettype none
module transient_triggered_noise_texture_test
    import ttnt_pkg::*;
();

    localparam int SB = 24;
    localparam longint LIMIT = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic [SB-1:0] s_axis_tdata = '0;  // [23:0] sample_in
    logic s_axis_tuser = 1'b0;         // [0] chan
    logic s_axis_tready;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [SB-1:0] m_axis_tdata;       // [23:0] sample_out
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    transient_triggered_noise_texture i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow registers and channel state of the predictor.
    logic [22:0] thresh_q;
    logic [1:0]  palette_q;
    logic [23:0] decay_q, fatt_q, frel_q, satt_q, srel_q;
    logic [16:0] mix_q;
    longint fast_q[2], slow_q[2], filt_q[2];
    logic [24:0] tex_env_q[2];
    logic [4:0]  phase_q[2];
    logic [15:0] holdoff_q[2];
    logic [31:0] lfsr_q;

    logic [SB-1:0] expected_samples[$];
    int  errors = 0;
    bit  quiet = 1'b0;   // sender or receiver never idles while set
    longint cycles = 0;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint env_follow(longint e, longint x, logic [23:0] a,
                                          logic [23:0] r);
        longint c;
        c = (x > e) ? longint'(a) : longint'(r);
        return e + floor_sh((x - e) * c, 24);
    endfunction

    function automatic logic [31:0] lfsr_adv();
        logic lsb;
        lsb = lfsr_q[0];
        lfsr_q = lfsr_q >> 1;
        if (lsb) lfsr_q = lfsr_q ^ LFSR_MASK;
        return lfsr_q;
    endfunction

    function automatic void reset_model();
        thresh_q = '0; palette_q = PAL_CRACKLE; decay_q = 24'hFFFFFF; mix_q = '0;
        fatt_q = '0; frel_q = '0; satt_q = '0; srel_q = '0;
        for (int c = 0; c < 2; c++) begin
            fast_q[c] = 0; slow_q[c] = 0; filt_q[c] = 0;
            tex_env_q[c] = '0; phase_q[c] = '0; holdoff_q[c] = '0;
        end
        lfsr_q = LFSR_SEED;
    endfunction

    // Works out the mixed output sample for one request and updates the state.
    function automatic logic [SB-1:0] predict_sample(logic ch, logic [SB-1:0] raw);
        longint x, mag, noise, tex, d, gain, y, mixv;
        longint one;
        logic [31:0] env;
        bit hit;
        one = 64'sd1 <<< (SB - 1);
        x = longint'($signed(raw));
        mag = x < 0 ? -x : x;
        fast_q[ch] = env_follow(fast_q[ch], mag, fatt_q, frel_q);
        slow_q[ch] = env_follow(slow_q[ch], mag, satt_q, srel_q);
        if (holdoff_q[ch] > 0) holdoff_q[ch]--;
        hit = (2 * fast_q[ch] > 5 * slow_q[ch]) && (fast_q[ch] > longint'(thresh_q));
        if (hit && holdoff_q[ch] == 0) begin
            tex_env_q[ch] = TEX_ONE;
            holdoff_q[ch] = 16'(3528);
        end
        env = 32'(tex_env_q[ch]);
        tex_env_q[ch] = 25'((longint'(env) * longint'(decay_q)) >> 24);
        noise = longint'(lfsr_adv() >> (32 - SB)) - one;
        tex = 0;
        case (palette_q)
            PAL_CRACKLE: begin
                if (lfsr_adv() < CRACKLE_LIMIT) tex = noise * 2;
            end
            PAL_SCRAPE: begin
                filt_q[ch] += floor_sh(noise - filt_q[ch], 1);
                d = noise - filt_q[ch];
                tex = d + floor_sh(d, 1);
            end
            PAL_WIND: begin
                filt_q[ch] += floor_sh((noise - filt_q[ch]) * longint'(WIND_COEF), 24);
                tex = filt_q[ch] * 6;
            end
            default: begin
                phase_q[ch] = phase_q[ch] + 5'd1;
                if (phase_q[ch] > HOLD_STEPS) begin
                    phase_q[ch] -= HOLD_STEPS;
                    filt_q[ch] = noise;
                end
                tex = filt_q[ch] + floor_sh(filt_q[ch], 1);
            end
        endcase
        if (tex > one) tex = one;
        if (tex < -one) tex = -one;
        mixv = mix_q > MIX_FULL ? longint'(MIX_FULL) : longint'(mix_q);
        gain = (longint'(env) * mixv) >> 16;
        y = x + floor_sh((tex - x) * gain, 24);
        if (y > one - 1) y = one - 1;
        if (y < -one) y = -one;
        return SB'(y);
    endfunction

    // Timeout guard.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random back-pressure and result checking.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample_out %0d", $time, $signed(m_axis_tdata));
                errors++;
            end else begin
                logic [SB-1:0] want;
                want = expected_samples.pop_front();
                if (want !== m_axis_tdata) begin
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             $signed(want), $signed(m_axis_tdata));
                    errors++;
                end
            end
        end
        m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 34);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_THRESH:  thresh_q = val[22:0];
            REG_PALETTE: palette_q = val[1:0];
            REG_DECAY:   decay_q = val[23:0];
            REG_MIX:     mix_q = val[16:0];
            REG_FATT:    fatt_q = val[23:0];
            REG_FREL:    frel_q = val[23:0];
            REG_SATT:    satt_q = val[23:0];
            default:     srel_q = val[23:0];
        endcase
    endtask

    // Sends one request, with a random idle gap before it.
    task automatic send_sample(logic ch, logic [SB-1:0] s);
        while (!quiet && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ch;
        s_axis_tdata <= s;
        expected_samples.push_back(predict_sample(ch, s));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_all(logic [22:0] th, logic [1:0] pal, logic [23:0] dec,
                           logic [16:0] mx, logic [23:0] fa, logic [23:0] fr,
                           logic [23:0] sa, logic [23:0] sr);
        write_reg(REG_THRESH, 32'(th));  write_reg(REG_PALETTE, 32'(pal));
        write_reg(REG_DECAY, 32'(dec));  write_reg(REG_MIX, 32'(mx));
        write_reg(REG_FATT, 32'(fa));    write_reg(REG_FREL, 32'(fr));
        write_reg(REG_SATT, 32'(sa));    write_reg(REG_SREL, 32'(sr));
    endtask

    function automatic logic [SB-1:0] rnd_sample();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return SB'($urandom_range(4095));
            default: return SB'($urandom);
        endcase
    endfunction

    // Field extremes and each palette with a clear transient, mix above full too.
    task automatic test_directed();
        set_all(23'd1000, PAL_CRACKLE, 24'hF00000, 17'h1FFFF,
                24'hFFFFFF, 24'h100000, 24'h010000, 24'h001000);
        for (int p = 0; p < 4; p++) begin
            drain();
            write_reg(REG_PALETTE, 32'(p));
            send_sample(1'b0, 24'h000000);
            send_sample(1'b1, 24'h7FFFFF);
            send_sample(1'b0, 24'h800000);
            send_sample(1'b1, 24'h000001);
            send_sample(1'b0, 24'hFFFFFF);
        end
        drain();
    endtask

    // Groups of mostly small samples mixed with loud ones, so transients and holdoffs are reached.
    task automatic test_random(int n, bit extremes);
        int sent;
        sent = 0;
        while (sent < n) begin
            drain();
            if (extremes)
                set_all($urandom_range(1) ? 23'h7FFFFF : 23'd0, 2'($urandom),
                        $urandom_range(1) ? 24'hFFFFFF : 24'd0, 17'd65536,
                        24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0);
            else
                set_all(23'($urandom_range(200000)), 2'($urandom),
                        24'($urandom_range(24'hFFFFFF, 24'hE00000)),
                        17'($urandom_range(70000)), 24'($urandom_range(24'hFFFFFF, 24'h400000)),
                        24'($urandom_range(24'h400000)), 24'($urandom_range(24'h40000)),
                        24'($urandom_range(24'h20000)));
            quiet = ($urandom_range(3) == 0);
            for (int k = 0; k < 60 && sent < n; k++, sent++) begin
                if ($urandom_range(9) < 6)
                    send_sample(1'($urandom), SB'($urandom_range(300)));
                else
                    send_sample(1'($urandom), rnd_sample());
            end
            quiet = 1'b0;
        end
        drain();
    endtask

    initial begin
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(100, 1'b1);
        test_random(1230, 1'b0);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
sv/ttnt_pkg.sv
sv/transient_triggered_noise_texture.sv
tb/transient_triggered_noise_texture_test.sv
